// File: sv/sdi_trs_pkg.sv
`default_nettype none

package sdi_trs_pkg;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // field widths
    localparam int WORD_W  = 10;
    localparam int LINE_W  = 11;
    localparam int POS_W   = 14;
    localparam int HANC_W  = 13;
    localparam int CRC_W   = 18;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 3;

    // crc-18 x^18+x^5+x^4+1, lsb first
    localparam logic [CRC_W-1:0] CRC_POLY = 18'h23000;

    // timing reference constants
    localparam logic [WORD_W-1:0] TRS_PREAMBLE = 10'h3FF;
    localparam logic [WORD_W-1:0] TRS_ZERO     = 10'h000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HANC_SYMBOLS        = 3'd0,
        CFG_ACTIVE_SYMBOLS      = 3'd1,
        CFG_TOTAL_LINES         = 3'd2,
        CFG_FIELD2_START_LINE   = 3'd3,
        CFG_FIELD1_ACTIVE_FIRST = 3'd4,
        CFG_FIELD1_ACTIVE_LAST  = 3'd5,
        CFG_FIELD2_ACTIVE_FIRST = 3'd6,
        CFG_FIELD2_ACTIVE_LAST  = 3'd7
    } cfg_index_t;

    // control from the word path to the crc accumulators
    typedef struct packed {
        logic              advance;
        logic              clear;
        logic              feed_en;
        logic              feed_ch;
        logic [WORD_W-1:0] feed_word;
    } crc_ctl_t;

    // one 10-bit word into the crc, one bit per step
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [WORD_W-1:0] word);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc_in;
        for (int b = 0; b < WORD_W; b++) begin
            fb = c[0] ^ word[b];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // xyz word with protection bits
    function automatic logic [WORD_W-1:0] xyz_word(input logic f, input logic v,
                                                   input logic h);
        return {1'b1, f, v, h, v ^ h, f ^ h, f ^ v, f ^ v ^ h, 2'b00};
    endfunction

    // word k of a four-word timing reference
    function automatic logic [WORD_W-1:0] trs_word(input logic [1:0] k,
                                                   input logic [WORD_W-1:0] xyz);
        logic [WORD_W-1:0] w;
        unique case (k)
            2'd0:    w = TRS_PREAMBLE;
            2'd3:    w = xyz;
            default: w = TRS_ZERO;
        endcase
        return w;
    endfunction

    // 9 data bits with bit 9 the inverse of bit 8
    function automatic logic [WORD_W-1:0] parity9(input logic [8:0] v);
        return {~v[8], v};
    endfunction

endpackage

`default_nettype wire

// File: sv/sdi_trs_crc.sv
`default_nettype none

module sdi_trs_crc
    import sdi_trs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire crc_ctl_t         ctl,
    output logic [CRC_W-1:0]      crc_first,
    output logic [CRC_W-1:0]      crc_second
);

    logic [CRC_W-1:0] crc_first_reg,  crc_first_next;
    logic [CRC_W-1:0] crc_second_reg, crc_second_next;
    logic [CRC_W-1:0] base_first, base_second;

    // clear at first active word, then feed the selected channel
    always_comb begin
        base_first  = ctl.clear ? '0 : crc_first_reg;
        base_second = ctl.clear ? '0 : crc_second_reg;
        crc_first_next  = base_first;
        crc_second_next = base_second;
        if (ctl.feed_en) begin
            if (ctl.feed_ch) begin
                crc_second_next = crc_feed(base_second, ctl.feed_word);
            end else begin
                crc_first_next = crc_feed(base_first, ctl.feed_word);
            end
        end
    end

    // accumulators move only when a word is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_first_reg  <= '0;
            crc_second_reg <= '0;
        end else if (ctl.advance) begin
            crc_first_reg  <= crc_first_next;
            crc_second_reg <= crc_second_next;
        end
    end

    assign crc_first  = crc_first_reg;
    assign crc_second = crc_second_reg;

endmodule

`default_nettype wire

// File: sv/sdi_line_trs_ln_crc_insert.sv
`default_nettype none

// channel   direction  handshake                 payload
// s_        in         s_tvalid / s_tready       s_tdata: data_word
// m_        out        m_tvalid / m_tready       m_tdata: video_word, line_number;
//                                                m_tlast: line_end; m_tuser: inserted
// cfg_      in         cfg_wr_en (no wait)       cfg_index, cfg_wdata
//
// one word per clock sustained while m_tready stays high; m_tvalid rises once
// the word has passed the input register and then the result register
// (fed by the timing/crc logic)
// reset: synchronous active-low aresetn, position 0, line 1, crc zero, registers
// at their defaults
// a stalled m_ side holds its word; one more word is taken into the input
// register, then s_tready drops until the result word is taken

module sdi_line_trs_ln_crc_insert
    import sdi_trs_pkg::*;
#(
    parameter int HD_INTERLEAVED   = 1,
    parameter int MAX_LINE_SYMBOLS = 8250
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] data_word
    // output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [9:0] video_word, [20:10] line_number
    output logic                       m_tlast,
    output logic                       m_tuser,   // [0] inserted
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    localparam logic [POS_W-1:0] MAX_SYM = POS_W'(MAX_LINE_SYMBOLS);
    localparam logic             HD_MODE = (HD_INTERLEAVED != 0);

    // configuration registers
    logic [HANC_W-1:0] hanc_reg, active_reg;
    logic [LINE_W-1:0] total_lines_reg, f2_start_reg;
    logic [LINE_W-1:0] f1_first_reg, f1_last_reg, f2_first_reg, f2_last_reg;

    // pipeline registers
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_data_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_ins_reg, out_end_reg;
    logic [LINE_W-1:0] out_line_reg;

    // raster counters
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [LINE_W-1:0] line_reg, line_next;

    logic              advance;
    logic [POS_W-1:0]  total_sum, total_len;
    logic              fld, vblank;
    logic [LINE_W-1:0] act_first, act_last;
    logic [WORD_W-1:0] xyz_eav, xyz_sav, tw, word_c;
    logic              ins_c, line_end_c;
    logic [POS_W:0]    pos_w, hanc_w, pos_p8, pos_p4, sav_d8, sav_d4;
    logic              sav_win8, sav_win4;
    logic [CRC_W-1:0]  crc_first, crc_second, crc_sel;
    crc_ctl_t          crc_ctl;

    // handshake: process when input full and result slot free or leaving
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hanc_reg        <= 13'd560;
            active_reg      <= 13'd3840;
            total_lines_reg <= 11'd1125;
            f2_start_reg    <= 11'd0;
            f1_first_reg    <= 11'd42;
            f1_last_reg     <= 11'd1121;
            f2_first_reg    <= 11'd0;
            f2_last_reg     <= 11'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HANC_SYMBOLS:        hanc_reg        <= cfg_wdata;
                CFG_ACTIVE_SYMBOLS:      active_reg      <= cfg_wdata;
                CFG_TOTAL_LINES:         total_lines_reg <= cfg_wdata[LINE_W-1:0];
                CFG_FIELD2_START_LINE:   f2_start_reg    <= cfg_wdata[LINE_W-1:0];
                CFG_FIELD1_ACTIVE_FIRST: f1_first_reg    <= cfg_wdata[LINE_W-1:0];
                CFG_FIELD1_ACTIVE_LAST:  f1_last_reg     <= cfg_wdata[LINE_W-1:0];
                CFG_FIELD2_ACTIVE_FIRST: f2_first_reg    <= cfg_wdata[LINE_W-1:0];
                CFG_FIELD2_ACTIVE_LAST:  f2_last_reg     <= cfg_wdata[LINE_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[WORD_W-1:0];
        end
    end

    // line length, clamped to the maximum and at least one
    always_comb begin
        total_sum = POS_W'(hanc_reg) + POS_W'(active_reg);
        if (total_sum > MAX_SYM) begin
            total_len = MAX_SYM;
        end else if (total_sum == '0) begin
            total_len = POS_W'(1);
        end else begin
            total_len = total_sum;
        end
    end

    // field and vertical blanking flags for the current line
    always_comb begin
        fld       = (f2_start_reg != '0) && (line_reg >= f2_start_reg);
        act_first = fld ? f2_first_reg : f1_first_reg;
        act_last  = fld ? f2_last_reg  : f1_last_reg;
        vblank    = (line_reg < act_first) || (line_reg > act_last);
        xyz_eav   = xyz_word(fld, vblank, 1'b1);
        xyz_sav   = xyz_word(fld, vblank, 1'b0);
    end

    // sav window positions
    always_comb begin
        pos_w    = {1'b0, pos_reg};
        hanc_w   = (POS_W+1)'(hanc_reg);
        pos_p8   = pos_w + (POS_W+1)'(8);
        pos_p4   = pos_w + (POS_W+1)'(4);
        sav_d8   = pos_p8 - hanc_w;
        sav_d4   = pos_p4 - hanc_w;
        sav_win8 = (pos_p8 >= hanc_w) && (pos_w < hanc_w);
        sav_win4 = (pos_p4 >= hanc_w) && (pos_w < hanc_w);
    end

    // word selection and crc control
    always_comb begin
        crc_sel = pos_reg[0] ? crc_second : crc_first;
        tw      = TRS_ZERO;
        word_c  = in_data_reg;
        ins_c   = 1'b0;
        crc_ctl = '0;
        crc_ctl.advance = advance;
        if (HD_MODE) begin
            // interleaved eav, ln and crc words
            if (pos_reg < POS_W'(16)) begin
                unique case (pos_reg[3:1])
                    3'd0, 3'd1, 3'd2, 3'd3:
                        tw = trs_word(pos_reg[2:1], xyz_eav);
                    3'd4:    tw = parity9({line_reg[6:0], 2'b00});
                    3'd5:    tw = parity9({3'b000, line_reg[10:7], 2'b00});
                    3'd6:    tw = parity9(crc_sel[8:0]);
                    default: tw = parity9(crc_sel[17:9]);
                endcase
                word_c = tw;
                ins_c  = 1'b1;
            end
            // sav wins over the leading timing words
            if (sav_win8) begin
                word_c = trs_word(sav_d8[2:1], xyz_sav);
                ins_c  = 1'b1;
            end
            crc_ctl.clear = (pos_w == hanc_w);
            if (pos_reg < POS_W'(12)) begin
                crc_ctl.feed_en   = 1'b1;
                crc_ctl.feed_ch   = pos_reg[0];
                crc_ctl.feed_word = tw;
            end else if ((pos_w >= hanc_w) && (pos_reg < total_len)) begin
                crc_ctl.feed_en   = 1'b1;
                crc_ctl.feed_ch   = pos_reg[0] ^ hanc_reg[0];
                crc_ctl.feed_word = in_data_reg;
            end
        end else begin
            // sd: four-word eav and sav only
            if (pos_reg < POS_W'(4)) begin
                word_c = trs_word(pos_reg[1:0], xyz_eav);
                ins_c  = 1'b1;
            end
            if (sav_win4) begin
                word_c = trs_word(sav_d4[1:0], xyz_sav);
                ins_c  = 1'b1;
            end
        end
    end

    // line end and counter wrap
    always_comb begin
        line_end_c = ((pos_w + (POS_W+1)'(1)) >= (POS_W+1)'(total_len));
        if (line_end_c) begin
            pos_next  = '0;
            line_next = (line_reg >= total_lines_reg) ? LINE_W'(1)
                                                      : line_reg + LINE_W'(1);
        end else begin
            pos_next  = pos_reg + POS_W'(1);
            line_next = line_reg;
        end
    end

    sdi_trs_crc u_crc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (crc_ctl),
        .crc_first  (crc_first),
        .crc_second (crc_second)
    );

    // raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            line_reg <= LINE_W'(1);
        end else if (advance) begin
            pos_reg  <= pos_next;
            line_reg <= line_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= word_c;
            out_ins_reg  <= ins_c;
            out_end_reg  <= line_end_c;
            out_line_reg <= line_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_line_reg, out_word_reg};
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_ins_reg;

    // checks
    a_pos_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && line_end_c |=> pos_reg == '0)
        else $error("position did not wrap at line end");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !line_end_c |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("position did not step by one");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");

endmodule

`default_nettype wire

// File: dv/sdi_raster_checker.sv
module sdi_raster_checker
    import sdi_trs_pkg::*;
#(
    parameter int HD_INTERLEAVED   = 1,
    parameter int MAX_LINE_SYMBOLS = 8250
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [9:0] data_word
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,   // [9:0] video_word, [20:10] line_number
    input  wire logic                 m_tlast,
    input  wire logic                 m_tuser,   // [0] inserted
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] video;
        logic              ins;
        logic              eol;
        logic [LINE_W-1:0] line;
    } raster_word_t;

    raster_word_t expected_words[$];
    int           mismatch_count = 0;

    // shadow copy of the raster registers
    logic [HANC_W-1:0] hanc_cfg, active_cfg;
    logic [LINE_W-1:0] lines_cfg, f2_start_cfg;
    logic [LINE_W-1:0] f1_first_cfg, f1_last_cfg, f2_first_cfg, f2_last_cfg;

    // raster position and per-channel crc
    logic [POS_W-1:0]  pos_q;
    logic [LINE_W-1:0] line_q;
    logic [CRC_W-1:0]  crc_ch0, crc_ch1;

    // crc-18, lsb first, one 10-bit word
    function automatic logic [CRC_W-1:0] crc18_take(input logic [CRC_W-1:0] c,
                                                    input logic [WORD_W-1:0] w);
        logic fb;
        for (int b = 0; b < WORD_W; b++) begin
            fb = c[0] ^ w[b];
            c  = {fb, c[17:15], c[14] ^ fb, c[13] ^ fb, c[12:1]};
        end
        return c;
    endfunction

    // nine payload bits, bit 9 inverted bit 8
    function automatic logic [WORD_W-1:0] guard9(input logic [8:0] v);
        return {~v[8], v};
    endfunction

    // word k of eav (h=1) or sav (h=0) for this line
    function automatic logic [WORD_W-1:0] timing_word(input int k,
                                                      input logic [LINE_W-1:0] line,
                                                      input logic h);
        logic              f, v;
        logic [LINE_W-1:0] first, last;
        f     = (f2_start_cfg != '0) && (line >= f2_start_cfg);
        first = f ? f2_first_cfg : f1_first_cfg;
        last  = f ? f2_last_cfg : f1_last_cfg;
        v     = (line < first) || (line > last);
        case (k)
            0:       return TRS_PREAMBLE;
            3:       return {1'b1, f, v, h, v ^ h, f ^ h, f ^ v, f ^ v ^ h, 2'b00};
            default: return '0;
        endcase
    endfunction

    // output word for one input word, advances position, line and crc
    function automatic raster_word_t step_raster(input logic [WORD_W-1:0] data);
        int                pos, hanc, total;
        logic [LINE_W-1:0] line;
        logic [WORD_W-1:0] w, tw;
        logic              ins, eol, ch;
        logic [CRC_W-1:0]  crc;
        raster_word_t      r;
        pos   = int'(pos_q);
        line  = line_q;
        hanc  = int'(hanc_cfg);
        total = int'(hanc_cfg) + int'(active_cfg);
        if (total > MAX_LINE_SYMBOLS) total = MAX_LINE_SYMBOLS;
        if (total == 0) total = 1;
        w   = data;
        tw  = '0;
        ins = 1'b0;

        if (HD_INTERLEAVED != 0) begin
            ch  = pos_q[0];
            crc = ch ? crc_ch1 : crc_ch0;
            // eav, ln and crc words on the first 16 symbols
            if (pos < 16) begin
                case (pos >> 1)
                    4:       tw = guard9({line[6:0], 2'b00});
                    5:       tw = guard9({3'b000, line[10:7], 2'b00});
                    6:       tw = guard9(crc[8:0]);
                    7:       tw = guard9(crc[17:9]);
                    default: tw = timing_word(pos >> 1, line, 1'b1);
                endcase
                w   = tw;
                ins = 1'b1;
            end
            // sav just ahead of active video wins over everything
            if (pos + 8 >= hanc && pos < hanc) begin
                w   = timing_word((pos + 8 - hanc) >> 1, line, 1'b0);
                ins = 1'b1;
            end
            if (pos == hanc) begin
                crc_ch0 = '0;
                crc_ch1 = '0;
            end
            // timing words feed their own channel, else active data by offset
            if (pos < 12) begin
                if (ch) crc_ch1 = crc18_take(crc_ch1, tw);
                else    crc_ch0 = crc18_take(crc_ch0, tw);
            end else if (pos >= hanc && pos < total) begin
                if (((pos - hanc) & 1) != 0) crc_ch1 = crc18_take(crc_ch1, data);
                else                         crc_ch0 = crc18_take(crc_ch0, data);
            end
        end else begin
            if (pos < 4) begin
                w   = timing_word(pos, line, 1'b1);
                ins = 1'b1;
            end
            if (pos + 4 >= hanc && pos < hanc) begin
                w   = timing_word(pos + 4 - hanc, line, 1'b0);
                ins = 1'b1;
            end
        end

        // line and frame wrap
        eol = (pos + 1 >= total);
        if (eol) begin
            pos_q  = '0;
            line_q = (line >= lines_cfg) ? LINE_W'(1) : line + LINE_W'(1);
        end else begin
            pos_q = pos_q + POS_W'(1);
        end

        r.video = w;
        r.ins   = ins;
        r.eol   = eol;
        r.line  = line;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        end
    endtask

    // watch config, input and output words
    always @(posedge aclk) begin
        raster_word_t want_w, got_w;
        if (!aresetn) begin
            hanc_cfg     = 13'd560;
            active_cfg   = 13'd3840;
            lines_cfg    = 11'd1125;
            f2_start_cfg = 11'd0;
            f1_first_cfg = 11'd42;
            f1_last_cfg  = 11'd1121;
            f2_first_cfg = 11'd0;
            f2_last_cfg  = 11'd0;
            pos_q        = '0;
            line_q       = LINE_W'(1);
            crc_ch0      = '0;
            crc_ch1      = '0;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_HANC_SYMBOLS:        hanc_cfg     = cfg_wdata;
                    CFG_ACTIVE_SYMBOLS:      active_cfg   = cfg_wdata;
                    CFG_TOTAL_LINES:         lines_cfg    = cfg_wdata[LINE_W-1:0];
                    CFG_FIELD2_START_LINE:   f2_start_cfg = cfg_wdata[LINE_W-1:0];
                    CFG_FIELD1_ACTIVE_FIRST: f1_first_cfg = cfg_wdata[LINE_W-1:0];
                    CFG_FIELD1_ACTIVE_LAST:  f1_last_cfg  = cfg_wdata[LINE_W-1:0];
                    CFG_FIELD2_ACTIVE_FIRST: f2_first_cfg = cfg_wdata[LINE_W-1:0];
                    CFG_FIELD2_ACTIVE_LAST:  f2_last_cfg  = cfg_wdata[LINE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_words.push_back(step_raster(s_tdata[WORD_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                got_w.video = m_tdata[WORD_W-1:0];
                got_w.line  = m_tdata[WORD_W +: LINE_W];
                got_w.eol   = m_tlast;
                got_w.ins   = m_tuser;
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: output word 0x%0h with nothing expected", $time, got_w);
                end else begin
                    want_w = expected_words.pop_front();
                    check_field("video_word", int'(want_w.video), int'(got_w.video));
                    check_field("inserted", int'(want_w.ins), int'(got_w.ins));
                    check_field("line_end", int'(want_w.eol), int'(got_w.eol));
                    check_field("line_number", int'(want_w.line), int'(got_w.line));
                end
            end
        end
        pending    <= expected_words.size();
        fail_count <= mismatch_count;
    end

endmodule

// File: dv/tb_sdi_line_trs_ln_crc_insert.sv
module tb_sdi_line_trs_ln_crc_insert;
    import sdi_trs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct {
        logic [CFG_W-1:0] hanc;
        logic [CFG_W-1:0] active;
        logic [CFG_W-1:0] total;
        logic [CFG_W-1:0] f2_start;
        logic [CFG_W-1:0] f1_first;
        logic [CFG_W-1:0] f1_last;
        logic [CFG_W-1:0] f2_first;
        logic [CFG_W-1:0] f2_last;
    } raster_cfg_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [9:0] data_word
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [9:0] video_word, [20:10] line_number
    logic                 m_tlast;
    logic                 m_tuser;          // [0] inserted
    logic                 cfg_wr_en = 1'b0;
    cfg_index_t           cfg_index = CFG_HANC_SYMBOLS;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          words_sent    = 0;
    int          tx_burst      = 0;
    logic        pressure_done = 1'b0;
    int unsigned cycle_count   = 0;

    sdi_line_trs_ln_crc_insert dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sdi_raster_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // one word into the block, after a random gap or none
    task automatic send_word(input logic [WORD_W-1:0] data);
        int gap, r;
        gap = 0;
        if (tx_burst > 0) begin
            tx_burst--;
        end else begin
            r = $urandom_range(0, 99);
            if (r >= 45 && r < 85) begin
                gap = $urandom_range(1, 3);
            end else if (r >= 85 && r < 95) begin
                tx_burst = $urandom_range(20, 100);
            end else if (r >= 95) begin
                gap = $urandom_range(8, 30);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - WORD_W){1'b0}}, data};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // stop sending and let every expected word come out
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    task automatic program_raster(input raster_cfg_t c);
        write_reg(CFG_HANC_SYMBOLS, c.hanc);
        write_reg(CFG_ACTIVE_SYMBOLS, c.active);
        write_reg(CFG_TOTAL_LINES, c.total);
        write_reg(CFG_FIELD2_START_LINE, c.f2_start);
        write_reg(CFG_FIELD1_ACTIVE_FIRST, c.f1_first);
        write_reg(CFG_FIELD1_ACTIVE_LAST, c.f1_last);
        write_reg(CFG_FIELD2_ACTIVE_FIRST, c.f2_first);
        write_reg(CFG_FIELD2_ACTIVE_LAST, c.f2_last);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // output side: random stalls, quiet stretches and one long hold
    initial begin : sink
        int hold, quiet, r;
        hold  = 0;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!pressure_done && words_sent >= 300) begin
                pressure_done = 1'b1;
                hold          = 400;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (quiet > 0) begin
                    quiet--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 20) begin
                        hold = $urandom_range(1, 3);
                    end else if (r < 23) begin
                        hold = $urandom_range(10, 40);
                    end else if (r < 26) begin
                        quiet = $urandom_range(30, 150);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        raster_cfg_t c;
        int          n, random_words;
        random_words = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // default raster: eav, ln and crc words with extreme and walking data
        send_word(10'h000);
        send_word(10'h3FF);
        for (int i = 0; i < WORD_W; i++) begin
            send_word(10'h001 << i);
        end
        send_word(10'h2AA);
        send_word(10'h155);
        send_word(10'h3FE);
        send_word(10'h200);
        settle();

        // shortest line, sav over the eav region, single-line frame,
        // upper wdata bits dropped on the 11-bit registers
        c = '{13'd8, 13'd2, 13'h1801, 13'h1000, 13'h0801, 13'h1801, 13'd0, 13'h17FF};
        program_raster(c);
        for (int i = 0; i < 11; i++) begin
            send_word(10'($urandom_range(0, 1023)));
        end
        settle();

        // start of the longest line, register extremes
        c = '{13'd8190, 13'd4096, 13'd2047, 13'd2047, 13'd1, 13'd2047, 13'd0, 13'd2047};
        program_raster(c);
        for (int i = 0; i < 100; i++) begin
            send_word(10'($urandom_range(0, 1023)));
        end
        settle();

        // short lines through many line numbers, interlaced fields
        c = '{13'd8, 13'd2, 13'd2047, 13'd70, 13'd3, 13'd60, 13'd75, 13'd125};
        program_raster(c);
        for (int i = 0; i < 1300; i++) begin
            send_word(10'($urandom_range(0, 1023)));
        end
        settle();

        // random small rasters
        while (random_words < 150) begin
            c.hanc     = CFG_W'($urandom_range(8, 48));
            c.active   = CFG_W'($urandom_range(2, 64));
            c.total    = CFG_W'($urandom_range(1, 10));
            c.f2_start = ($urandom_range(0, 2) == 0) ? '0
                                                     : CFG_W'($urandom_range(1, c.total + 1));
            c.f1_first = CFG_W'($urandom_range(1, c.total + 1));
            c.f1_last  = CFG_W'($urandom_range(1, c.total + 1));
            c.f2_first = CFG_W'($urandom_range(0, c.total + 1));
            c.f2_last  = CFG_W'($urandom_range(0, c.total + 1)
                                | ($urandom_range(0, 3) << LINE_W));
            program_raster(c);
            n = $urandom_range(30, 100);
            for (int i = 0; i < n; i++) begin
                send_word(10'($urandom_range(0, 1023)));
            end
            random_words += n;
            settle();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
